// ===== design/dts_pkg.sv =====
package dts_pkg;

    localparam int DTS_MAX_ITEMS = 16;
    localparam int DTS_VALUE_W   = 32;
    localparam int DTS_TAG_W     = 8;

    // One stored entry of the sorting chain.
    typedef struct packed {
        logic                          valid;
        logic signed [DTS_VALUE_W-1:0] value;
        logic        [DTS_TAG_W-1:0]   tag;
    } t_entry;

    // Shared control that every cell of the chain sees in the same cycle.
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctrl;

endpackage

// ===== design/dts_in_if.sv =====
interface dts_in_if
    import dts_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [DTS_VALUE_W-1:0] sale_value;
    logic        [DTS_TAG_W-1:0]   item_tag;
    logic                          is_last;

    modport source (output valid, output sale_value, output item_tag, output is_last,
                    input ready);
    modport sink   (input valid, input sale_value, input item_tag, input is_last,
                    output ready);
endinterface

// ===== design/dts_out_if.sv =====
interface dts_out_if
    import dts_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [DTS_VALUE_W-1:0] sorted_value;
    logic        [DTS_TAG_W-1:0]   sorted_tag;
    logic                          run_end;

    modport source (output valid, output sorted_value, output sorted_tag, output run_end,
                    input ready);
    modport sink   (input valid, input sorted_value, input sorted_tag, input run_end,
                    output ready);
endinterface

// ===== design/dts_cell.sv =====
module dts_cell
    import dts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  t_entry     i_prev,
    input  logic       i_prev_less,
    input  t_entry     i_next,
    output t_entry     o_entry,
    output logic       o_less
);

    logic                          r_valid;
    logic signed [DTS_VALUE_W-1:0] r_value;
    logic        [DTS_TAG_W-1:0]   r_tag;
    t_entry                        n_entry;

    // An empty cell or one holding a strictly smaller value yields to the new
    // request; equal values stay ahead, which keeps ties in arrival order.
    assign o_less = !r_valid || (r_value < i_new.value);

    always_comb begin
        n_entry = '{valid: r_valid, value: r_value, tag: r_tag};
        if (i_ctrl.pop) begin
            n_entry = i_next;
        end else if (i_ctrl.insert && o_less) begin
            if (i_prev_less) begin
                n_entry = i_prev;
            end else begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_entry.value;
        r_tag   <= n_entry.tag;
    end

    assign o_entry = '{valid: r_valid, value: r_value, tag: r_tag};

endmodule

// ===== design/descending_tagged_sorter_core.sv =====
// Sorts a run of signed values with their tags into descending order, ties in
// arrival order. A row of MAX_ITEMS cells keeps the run sorted as it loads: each
// request is compared against every cell at once and the smaller entries shift
// one place down, so loading takes one request per cycle. A run closes on a
// request marked is_last or on the MAX_ITEMS-th request. The chain then shifts
// toward its head one place per cycle while the output register is free or the
// sink takes its result, each shift moving the head entry into the output
// register; run_end marks the final one. Input ready stays low from the closing
// request until that final result has entered the output register.
module descending_tagged_sorter_core
    import dts_pkg::*;
#(
    parameter int MAX_ITEMS = DTS_MAX_ITEMS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dts_in_if.sink      i_in,
    dts_out_if.source   o_out
);

    t_entry                        w_entry [MAX_ITEMS];
    logic   [MAX_ITEMS-1:0]        w_less;
    logic   [MAX_ITEMS-1:0]        w_valid;
    t_cell_ctrl                    w_ctrl;
    t_entry                        w_new;
    logic                          w_accept;
    logic                          w_pop;
    logic                          w_run_end;

    logic                          r_drain;
    logic                          n_drain;
    logic                          r_out_valid;
    logic signed [DTS_VALUE_W-1:0] r_out_value;
    logic        [DTS_TAG_W-1:0]   r_out_tag;
    logic                          r_out_end;

    assign i_in.ready = !r_drain;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_pop      = r_drain && (!r_out_valid || o_out.ready);
    assign w_new      = '{valid: 1'b1, value: i_in.sale_value, tag: i_in.item_tag};
    assign w_ctrl     = '{insert: w_accept, pop: w_pop};

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
            t_entry w_prev;
            logic   w_prev_less;
            t_entry w_next;

            if (g == 0) begin : g_head
                assign w_prev      = '0;
                assign w_prev_less = 1'b0;
            end else begin : g_body
                assign w_prev      = w_entry[g-1];
                assign w_prev_less = w_less[g-1];
            end

            if (g == MAX_ITEMS - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_link
                assign w_next = w_entry[g+1];
            end

            dts_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_new       (w_new),
                .i_prev      (w_prev),
                .i_prev_less (w_prev_less),
                .i_next      (w_next),
                .o_entry     (w_entry[g]),
                .o_less      (w_less[g])
            );

            assign w_valid[g] = w_entry[g].valid;
        end
    endgenerate

    // The head entry is the final one of the run when nothing stands behind it.
    assign w_run_end = !w_valid[1];

    always_comb begin
        n_drain = r_drain;
        if (w_accept && (i_in.is_last || w_valid[MAX_ITEMS-2])) begin
            n_drain = 1'b1;
        end else if (w_pop && w_run_end) begin
            n_drain = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_drain <= n_drain;
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_value <= w_entry[0].value;
            r_out_tag   <= w_entry[0].tag;
            r_out_end   <= w_run_end;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.sorted_tag   = r_out_tag;
    assign o_out.run_end      = r_out_end;

`ifndef NO_ASSERTIONS
    // Occupied cells always form an unbroken block from the head of the chain.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("occupied cells are not contiguous");

    // Outside a drain the chain never holds a full run.
    a_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_drain |-> !w_valid[MAX_ITEMS-1])
        else $error("chain full while loading");

    // Sending the final result empties the chain and reopens the input.
    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_run_end) |=> (!r_drain && (w_valid == '0)))
        else $error("chain not empty after final result");

    // Throughout a drain there is always at least one entry at the head.
    a_drain_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> w_valid[0])
        else $error("drain with empty head cell");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dts_pkg::*;

    localparam int SORT_DEPTH   = DTS_MAX_ITEMS;
    localparam int IDLE_PCT     = 14;
    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 100;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [DTS_VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DTS_VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DTS_VALUE_W-1:0] value;
        logic        [DTS_TAG_W-1:0]   tag;
        logic                          last;
    } t_sale_req;

    typedef struct packed {
        logic signed [DTS_VALUE_W-1:0] value;
        logic        [DTS_TAG_W-1:0]   tag;
        logic                          run_end;
    } t_sorted_result;

    logic clk = 1'b0;
    logic rst_n;

    dts_in_if  in_ch ();
    dts_out_if out_ch ();

    descending_tagged_sorter_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    t_sale_req      pending_reqs[$];
    t_sorted_result expected_sorted[$];

    // Shadow of the sorted store for the run that is still loading.
    logic signed [DTS_VALUE_W-1:0] shadow_value[SORT_DEPTH];
    logic        [DTS_TAG_W-1:0]   shadow_tag[SORT_DEPTH];
    int shadow_fill;

    int reqs_accepted;
    int results_seen;
    int mismatches;
    int hold_left;
    logic hold_done;
    int stall_cycles;

    task automatic insert_and_close(input t_sale_req req);
        int n;
        int pos;
        int i;
        t_sorted_result res;
        n = shadow_fill;
        if (n >= SORT_DEPTH) n = 0;
        pos = n;
        // The new entry goes behind every entry that is greater or equal.
        for (i = 0; i < n; i++) begin
            if (shadow_value[i] < req.value) begin
                pos = i;
                break;
            end
        end
        for (i = n; i > pos; i--) begin
            shadow_value[i] = shadow_value[i-1];
            shadow_tag[i]   = shadow_tag[i-1];
        end
        shadow_value[pos] = req.value;
        shadow_tag[pos]   = req.tag;
        n++;
        if (!req.last && n < SORT_DEPTH) begin
            shadow_fill = n;
        end else begin
            for (i = 0; i < n; i++) begin
                res.value   = shadow_value[i];
                res.tag     = shadow_tag[i];
                res.run_end = (i == n - 1);
                expected_sorted.push_back(res);
            end
            shadow_fill = 0;
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at %0t on result %0d: %s expected %h got %h",
                     $realtime, results_seen, field, exp_v, act_v);
        mismatches++;
    endtask

    task automatic push_req(input logic signed [DTS_VALUE_W-1:0] v,
                            input logic [DTS_TAG_W-1:0] t, input logic l);
        t_sale_req req;
        req.value = v;
        req.tag   = t;
        req.last  = l;
        pending_reqs.push_back(req);
    endtask

    function automatic logic signed [DTS_VALUE_W-1:0] pick_value();
        logic signed [DTS_VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = int'($urandom_range(0, 8)) - 4;
            1: begin
                case ($urandom_range(0, 3))
                    0: v = VALUE_MAX;
                    1: v = VALUE_MIN;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            2: v = int'($urandom_range(0, 200)) - 100;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic logic tx_idle();
        if (reqs_accepted >= 200 && reqs_accepted < 300) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    function automatic logic rx_idle();
        if (results_seen >= 200 && results_seen < 300) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // Request driver.
    always @(posedge clk) begin : req_driver
        t_sale_req next_req;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                next_req.value = in_ch.sale_value;
                next_req.tag   = in_ch.item_tag;
                next_req.last  = in_ch.is_last;
                insert_and_close(next_req);
                reqs_accepted <= reqs_accepted + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_reqs.size() > 0 && !tx_idle()) begin
                    next_req = pending_reqs.pop_front();
                    in_ch.sale_value <= next_req.value;
                    in_ch.item_tag   <= next_req.tag;
                    in_ch.is_last    <= next_req.last;
                    in_ch.valid      <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker.
    always @(posedge clk) begin : result_monitor
        t_sorted_result exp_res;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_sorted.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result at %0t: value %h tag %h run_end %b",
                                 $realtime, out_ch.sorted_value, out_ch.sorted_tag,
                                 out_ch.run_end);
                    mismatches++;
                end else begin
                    exp_res = expected_sorted.pop_front();
                    if (out_ch.sorted_value !== exp_res.value)
                        report_mismatch("sorted_value", exp_res.value, out_ch.sorted_value);
                    if (out_ch.sorted_tag !== exp_res.tag)
                        report_mismatch("sorted_tag", 32'(exp_res.tag),
                                        32'(out_ch.sorted_tag));
                    if (out_ch.run_end !== exp_res.run_end)
                        report_mismatch("run_end", 32'(exp_res.run_end),
                                        32'(out_ch.run_end));
                end
                results_seen <= results_seen + 1;
            end
            out_ch.ready <= (hold_left == 0) && !rx_idle();
        end
    end

    // One long hold-off on the result side so the sorter fills and stalls its input.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            stall_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("FAIL descending_tagged_sorter_core");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int run_len;
        int i;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.sale_value = '0;
        in_ch.item_tag   = '0;
        in_ch.is_last    = 1'b0;
        out_ch.ready     = 1'b0;
        shadow_fill      = 0;
        reqs_accepted    = 0;
        results_seen     = 0;
        mismatches       = 0;

        // Single-entry run at the top of the range.
        push_req(VALUE_MAX, 8'hFF, 1'b1);
        // Extremes, sign boundary and ties that must keep arrival order.
        push_req(VALUE_MIN, 8'h00, 1'b0);
        push_req(0, 8'hAA, 1'b0);
        push_req(-1, 8'h55, 1'b0);
        push_req(1, 8'h01, 1'b0);
        push_req(5, 8'h02, 1'b0);
        push_req(5, 8'h03, 1'b0);
        push_req(VALUE_MAX, 8'h04, 1'b0);
        push_req(5, 8'h05, 1'b1);
        // A full store closes the run without is_last.
        for (i = 0; i < SORT_DEPTH; i++)
            push_req((i % 2) ? i * 1000 : -i * 1000, DTS_TAG_W'(i), 1'b0);

        while (pending_reqs.size() < RANDOM_ITEMS + 25) begin
            if ($urandom_range(0, 3) == 0) run_len = SORT_DEPTH;
            else run_len = $urandom_range(1, SORT_DEPTH);
            for (i = 0; i < run_len; i++) begin
                if (i < run_len - 1)
                    push_req(pick_value(), DTS_TAG_W'($urandom_range(0, 255)), 1'b0);
                else if (run_len == SORT_DEPTH)
                    push_req(pick_value(), DTS_TAG_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                else
                    push_req(pick_value(), DTS_TAG_W'($urandom_range(0, 255)), 1'b1);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_reqs.size() != 0 || in_ch.valid) @(posedge clk);
        while (expected_sorted.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_sorted.size() == 0) begin
            $display("PASS descending_tagged_sorter_core");
        end else begin
            $display("FAIL descending_tagged_sorter_core");
        end
        $finish;
    end

endmodule
